/* src/xte_pkg.sv */
// Shared types, codes and character constants of the XML tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package xte_pkg;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int DEPTH_BITS_DEF  = 16;
	localparam int LOOKAHEAD       = 8;
	localparam int BUF_LEN         = LOOKAHEAD + 1;
	localparam int JOB_FIFO_DEPTH  = 4;

	localparam logic [2:0] EV_OPEN    = 3'd0;
	localparam logic [2:0] EV_CLOSE   = 3'd1;
	localparam logic [2:0] EV_ATTR    = 3'd2;
	localparam logic [2:0] EV_ENDATTR = 3'd3;
	localparam logic [2:0] EV_TEXT    = 3'd4;
	localparam logic [2:0] EV_DONE    = 3'd5;
	localparam logic [2:0] EV_ERR     = 3'd6;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_OPEN  = 3'd1;
	localparam logic [2:0] ERR_CLOSE = 3'd2;
	localparam logic [2:0] ERR_ATTR  = 3'd3;
	localparam logic [2:0] ERR_DEPTH = 3'd4;

	localparam int K_OPEN  = 0;
	localparam int K_CLOSE = 1;
	localparam int K_TEXT  = 2;
	localparam int K_ANS   = 3;
	localparam int K_ANE   = 4;
	localparam int K_AVS   = 5;
	localparam int N_MARKS = 6;

	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_QM   = 8'h3F;
	localparam logic [7:0] CH_SL   = 8'h2F;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_RSB  = 8'h5D;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] NAME_HI = 8'd122;

	typedef enum logic [3:0] {
		M_TEXT, M_OPEN, M_CLOSE, M_APRE, M_ANAME, M_AEQ, M_AVAL, M_CDATA, M_COMM, M_HALT
	} mode_t;

	typedef enum logic {FS_RUN, FS_DRAIN} front_state_t;

	typedef struct packed {
		logic       fin;
		logic       step_last;
		logic [7:0] c;
		logic [7:0] nxt;
		logic       m_cdata;
		logic       m_comm;
		logic       m_ecomm;
		logic       m_ecdata;
		logic       m_close;
		logic       m_head;
	} job_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  code;
		logic [15:0] depth;
		logic [31:0] ns;
		logic [31:0] ne;
		logic [31:0] vs;
		logic [31:0] ve;
		logic        last;
	} event_t;
endpackage
`default_nettype wire

/* src/xte_front.sv */
// Front end: lookahead window, byte offset, marker matching and job generation.
`timescale 1ns / 1ps
`default_nettype none
module xte_front import xte_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,
	input  wire logic                   s_tlast,
	input  wire logic                   full,
	output logic                        push,
	output job_t                        job,
	output logic [OFFSET_BITS-1:0]      job_off
);
	localparam logic [BUF_LEN-1:0][7:0] MK_CDATA  = "<![CDATA[";
	localparam logic [BUF_LEN-1:0][7:0] MK_COMM   = {"<!--", 40'h0};
	localparam logic [BUF_LEN-1:0][7:0] MK_ECOMM  = {"-->", 48'h0};
	localparam logic [BUF_LEN-1:0][7:0] MK_ECDATA = {"]]>", 48'h0};
	localparam logic [BUF_LEN-1:0][7:0] MK_CLOSE  = {"</", 56'h0};
	localparam logic [BUF_LEN-1:0][7:0] MK_HEAD   = {"<?", 56'h0};

	function automatic logic match_at(input logic [BUF_LEN-1:0][7:0] b, input logic [3:0] n,
			input logic [BUF_LEN-1:0][7:0] m, input logic [3:0] len);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < BUF_LEN; k++) begin
			if (4'(k) < len && (4'(k) >= n || b[k] != m[BUF_LEN-1-k]))
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic job_t make_job(input logic [BUF_LEN-1:0][7:0] b, input logic [3:0] n,
			input logic last);
		job_t j;
		j.fin       = 1'b0;
		j.step_last = last;
		j.c         = b[0];
		j.nxt       = (n > 4'd1) ? b[1] : 8'h00;
		j.m_cdata   = match_at(b, n, MK_CDATA, 4'd9);
		j.m_comm    = match_at(b, n, MK_COMM, 4'd4);
		j.m_ecomm   = match_at(b, n, MK_ECOMM, 4'd3);
		j.m_ecdata  = match_at(b, n, MK_ECDATA, 4'd3);
		j.m_close   = match_at(b, n, MK_CLOSE, 4'd2);
		j.m_head    = match_at(b, n, MK_HEAD, 4'd2);
		return j;
	endfunction

	front_state_t                 state_q;
	logic [LOOKAHEAD-1:0][7:0]    win_q;
	logic [3:0]                   fill_q;
	logic [OFFSET_BITS-1:0]       off_q;
	logic [BUF_LEN-1:0][7:0]      drn_q;
	logic [3:0]                   drn_n_q;
	logic [OFFSET_BITS-1:0]       drn_off_q;

	logic [BUF_LEN-1:0][7:0]      bufw;
	logic                         nz;
	logic                         ended;
	logic                         accept;
	logic                         full_win;
	logic [3:0]                   n_cnt;

	always_comb begin
		nz       = s_tdata != 8'h00;
		ended    = !nz || s_tlast;
		full_win = fill_q == 4'(LOOKAHEAD);
		n_cnt    = fill_q + {3'b000, nz};
		for (int k = 0; k < LOOKAHEAD; k++) begin
			if (4'(k) < fill_q)
				bufw[k] = win_q[k];
			else if (4'(k) == fill_q && nz)
				bufw[k] = s_tdata;
			else
				bufw[k] = 8'h00;
		end
		bufw[LOOKAHEAD] = (full_win && nz) ? s_tdata : 8'h00;

		s_tready = state_q == FS_RUN && !full;
		accept   = s_tvalid && s_tready;
		push     = 1'b0;
		job      = '0;
		job_off  = off_q - OFFSET_BITS'(LOOKAHEAD);
		if (state_q == FS_RUN) begin
			if (accept && !ended && full_win) begin
				push = 1'b1;
				job  = make_job(bufw, 4'(BUF_LEN), 1'b1);
			end
		end else if (!full) begin
			push    = 1'b1;
			job_off = drn_off_q;
			if (drn_n_q != 4'd0) begin
				job = make_job(drn_q, drn_n_q, 1'b0);
			end else begin
				job.fin       = 1'b1;
				job.step_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_RUN;
			fill_q  <= 4'd0;
			off_q   <= '0;
			drn_n_q <= 4'd0;
		end else if (state_q == FS_RUN) begin
			if (accept) begin
				if (ended) begin
					drn_n_q <= n_cnt;
					fill_q  <= 4'd0;
					off_q   <= '0;
					state_q <= FS_DRAIN;
				end else if (full_win) begin
					off_q <= off_q + OFFSET_BITS'(1);
				end else begin
					fill_q <= fill_q + 4'd1;
					off_q  <= off_q + OFFSET_BITS'(1);
				end
			end
		end else if (!full) begin
			if (drn_n_q != 4'd0)
				drn_n_q <= drn_n_q - 4'd1;
			else
				state_q <= FS_RUN;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_RUN && accept) begin
			if (ended) begin
				drn_q     <= bufw;
				drn_off_q <= off_q - OFFSET_BITS'(fill_q);
			end else if (full_win) begin
				win_q <= bufw[BUF_LEN-1:1];
			end else begin
				win_q[fill_q[2:0]] <= s_tdata;
			end
		end else if (state_q == FS_DRAIN && !full && drn_n_q != 4'd0) begin
			drn_q     <= {8'h00, drn_q[BUF_LEN-1:1]};
			drn_off_q <= drn_off_q + OFFSET_BITS'(1);
		end
	end
endmodule
`default_nettype wire

/* src/xte_job_fifo.sv */
// Short job queue between the front end and the event engine.
`timescale 1ns / 1ps
`default_nettype none
module xte_job_fifo import xte_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = JOB_FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  valid
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

/* src/xte_back.sv */
// Event engine: parse mode, depth and span marks, event buffer and output stage.
`timescale 1ns / 1ps
`default_nettype none
module xte_back import xte_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   job_valid,
	input  wire job_t                   job,
	input  wire logic [OFFSET_BITS-1:0] job_off,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output event_t                      ev
);
	localparam logic signed [DEPTH_BITS-1:0] D_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] D_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic signed [DEPTH_BITS-1:0] D_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

	function automatic logic is_name(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c < NAME_HI);
	endfunction

	function automatic event_t mk_ev(input logic [2:0] kind, input logic [2:0] code,
			input logic signed [DEPTH_BITS-1:0] d, input logic [OFFSET_BITS-1:0] ns,
			input logic [OFFSET_BITS-1:0] ne, input logic [OFFSET_BITS-1:0] vs,
			input logic [OFFSET_BITS-1:0] ve);
		event_t e;
		e.kind  = kind;
		e.code  = code;
		e.depth = 16'(d);
		e.ns    = 32'(ns);
		e.ne    = 32'(ne);
		e.vs    = 32'(vs);
		e.ve    = 32'(ve);
		e.last  = 1'b0;
		return e;
	endfunction

	mode_t                         mode_q, n_mode;
	logic [3:0]                    skip_q, n_skip;
	logic signed [DEPTH_BITS-1:0]  depth_q, n_depth;
	logic [OFFSET_BITS-1:0]        mark_q [N_MARKS];
	logic [OFFSET_BITS-1:0]        n_mark [N_MARKS];
	logic [N_MARKS-1:0]            mvalid_q, n_mvalid;

	event_t                        ev_q [3];
	event_t                        nev [3];
	logic [1:0]                    ev_cnt_q, ev_ptr_q, ncnt;
	logic                          drain_last;
	logic [OFFSET_BITS-1:0]        off;
	localparam logic [OFFSET_BITS-1:0] Z = '0;

	assign m_tvalid   = ev_cnt_q != 2'd0;
	assign ev         = ev_q[ev_ptr_q];
	assign drain_last = m_tvalid && m_tready && (ev_ptr_q == ev_cnt_q - 2'd1);
	assign pop        = job_valid && (ev_cnt_q == 2'd0 || drain_last);
	assign off        = job_off;

	always_comb begin
		n_mode   = mode_q;
		n_skip   = skip_q;
		n_depth  = depth_q;
		n_mark   = mark_q;
		n_mvalid = mvalid_q;
		ncnt     = 2'd0;
		nev[0]   = '0;
		nev[1]   = '0;
		nev[2]   = '0;
		if (job.fin) begin
			if (mode_q != M_HALT) begin
				if (depth_q != '0)
					nev[0] = mk_ev(EV_ERR, ERR_DEPTH, depth_q, Z, Z, Z, Z);
				else
					nev[0] = mk_ev(EV_DONE, ERR_NONE, depth_q, Z, Z, Z, Z);
				ncnt = 2'd1;
			end
			n_mode   = M_TEXT;
			n_skip   = 4'd0;
			n_depth  = '0;
			n_mvalid = '0;
		end else if (mode_q == M_HALT) begin
			n_mode = M_HALT;
		end else if (skip_q != 4'd0) begin
			n_skip = skip_q - 4'd1;
		end else begin
			case (job.c) inside
				CH_LT: begin
					if (mode_q == M_TEXT) begin
						if (job.m_cdata) begin
							n_mode = M_CDATA;
							n_skip = 4'd8;
							n_mark[K_TEXT] = off + OFFSET_BITS'(9);
							n_mvalid[K_TEXT] = 1'b1;
						end else if (job.m_comm) begin
							n_mode = M_COMM;
							n_skip = 4'd3;
						end else if (job.m_close) begin
							n_mode = M_CLOSE;
							if (mvalid_q[K_TEXT]) begin
								nev[0] = mk_ev(EV_TEXT, ERR_NONE, depth_q, mark_q[K_TEXT], off,
									Z, Z);
								ncnt = 2'd1;
							end
							n_mvalid[K_TEXT] = 1'b0;
							n_skip = 4'd1;
							n_mark[K_CLOSE] = off + OFFSET_BITS'(2);
							n_mvalid[K_CLOSE] = 1'b1;
						end else if (job.m_head) begin
							n_mode = M_OPEN;
							n_skip = 4'd1;
							n_mark[K_OPEN] = off + OFFSET_BITS'(2);
							n_mvalid[K_OPEN] = 1'b1;
						end else begin
							n_mode = M_OPEN;
							n_mark[K_OPEN] = off + OFFSET_BITS'(1);
							n_mvalid[K_OPEN] = 1'b1;
						end
					end
				end
				CH_QM, CH_SL: begin
					if (mode_q == M_APRE) begin
						if (job.nxt == CH_GT) begin
							nev[0] = mk_ev(EV_ENDATTR, ERR_NONE, depth_q, Z, Z, Z, Z);
							nev[1] = mk_ev(EV_CLOSE, ERR_NONE, depth_q, off, off, Z, Z);
							ncnt = 2'd2;
							n_mode = M_TEXT;
							n_skip = 4'd1;
							n_depth = (depth_q == D_MIN) ? depth_q : depth_q - D_ONE;
						end
					end else if (mode_q == M_OPEN) begin
						if (job.nxt != CH_GT || !mvalid_q[K_OPEN]) begin
							nev[0] = mk_ev(EV_ERR, ERR_OPEN, depth_q, Z, Z, Z, Z);
							ncnt = 2'd1;
							n_mode = M_HALT;
						end else begin
							n_mode = M_TEXT;
							n_skip = 4'd1;
							n_depth = (depth_q == D_MAX) ? depth_q : depth_q + D_ONE;
							nev[0] = mk_ev(EV_OPEN, ERR_NONE, n_depth, mark_q[K_OPEN], off, Z, Z);
							nev[1] = mk_ev(EV_ENDATTR, ERR_NONE, n_depth, Z, Z, Z, Z);
							nev[2] = mk_ev(EV_CLOSE, ERR_NONE, n_depth, off, off, Z, Z);
							ncnt = 2'd3;
							n_mvalid[K_OPEN] = 1'b0;
							n_depth = (n_depth == D_MIN) ? n_depth : n_depth - D_ONE;
						end
					end
				end
				CH_GT: begin
					if (mode_q == M_APRE) begin
						nev[0] = mk_ev(EV_ENDATTR, ERR_NONE, depth_q, Z, Z, Z, Z);
						ncnt = 2'd1;
						n_mode = M_TEXT;
						n_mark[K_TEXT] = off + OFFSET_BITS'(1);
						n_mvalid[K_TEXT] = 1'b1;
					end else if (mode_q == M_CLOSE) begin
						n_mode = M_TEXT;
						if (!mvalid_q[K_CLOSE]) begin
							nev[0] = mk_ev(EV_ERR, ERR_CLOSE, depth_q, Z, Z, Z, Z);
							n_mode = M_HALT;
						end else begin
							nev[0] = mk_ev(EV_CLOSE, ERR_NONE, depth_q, mark_q[K_CLOSE], off,
								Z, Z);
							n_depth = (depth_q == D_MIN) ? depth_q : depth_q - D_ONE;
							n_mvalid[K_CLOSE] = 1'b0;
						end
						ncnt = 2'd1;
					end else if (mode_q == M_OPEN) begin
						n_mode = M_TEXT;
						n_mark[K_TEXT] = off + OFFSET_BITS'(1);
						n_mvalid[K_TEXT] = 1'b1;
						if (!mvalid_q[K_OPEN]) begin
							nev[0] = mk_ev(EV_ERR, ERR_OPEN, depth_q, Z, Z, Z, Z);
							ncnt = 2'd1;
							n_mode = M_HALT;
						end else begin
							n_depth = (depth_q == D_MAX) ? depth_q : depth_q + D_ONE;
							nev[0] = mk_ev(EV_OPEN, ERR_NONE, n_depth, mark_q[K_OPEN], off, Z, Z);
							nev[1] = mk_ev(EV_ENDATTR, ERR_NONE, n_depth, Z, Z, Z, Z);
							ncnt = 2'd2;
							n_mvalid[K_OPEN] = 1'b0;
						end
					end
				end
				CH_DQ: begin
					if (mode_q == M_AEQ) begin
						n_mode = M_AVAL;
						n_mark[K_AVS] = off + OFFSET_BITS'(1);
						n_mvalid[K_AVS] = 1'b1;
					end else if (mode_q == M_AVAL) begin
						n_mode = M_APRE;
						ncnt = 2'd1;
						if (!mvalid_q[K_ANS] || !mvalid_q[K_ANE] || !mvalid_q[K_AVS]) begin
							nev[0] = mk_ev(EV_ERR, ERR_ATTR, depth_q, Z, Z, Z, Z);
							n_mode = M_HALT;
						end else begin
							nev[0] = mk_ev(EV_ATTR, ERR_NONE, depth_q, mark_q[K_ANS],
								mark_q[K_ANE], mark_q[K_AVS], off);
							n_mvalid[K_ANS] = 1'b0;
							n_mvalid[K_ANE] = 1'b0;
							n_mvalid[K_AVS] = 1'b0;
						end
					end
				end
				CH_DASH: begin
					if (mode_q == M_COMM && job.m_ecomm) begin
						n_mode = M_TEXT;
						n_skip = 4'd2;
					end
				end
				CH_RSB: begin
					if (mode_q == M_CDATA && job.m_ecdata) begin
						n_mode = M_TEXT;
						if (mvalid_q[K_TEXT]) begin
							nev[0] = mk_ev(EV_TEXT, ERR_NONE, depth_q, mark_q[K_TEXT], off, Z, Z);
							ncnt = 2'd1;
						end
						n_mvalid[K_TEXT] = 1'b0;
						n_skip = 4'd2;
					end
				end
				CH_EQ: begin
					if (mode_q == M_ANAME) begin
						n_mode = M_AEQ;
						if (!mvalid_q[K_ANE]) begin
							n_mark[K_ANE] = off;
							n_mvalid[K_ANE] = 1'b1;
						end
					end
				end
				CH_SP, CH_TAB, CH_CR, CH_LF: begin
					if (mode_q == M_ANAME) begin
						if (!mvalid_q[K_ANE]) begin
							n_mark[K_ANE] = off;
							n_mvalid[K_ANE] = 1'b1;
						end
					end else if (mode_q == M_OPEN) begin
						n_mode = M_APRE;
						ncnt = 2'd1;
						if (!mvalid_q[K_OPEN]) begin
							nev[0] = mk_ev(EV_ERR, ERR_OPEN, depth_q, Z, Z, Z, Z);
							n_mode = M_HALT;
						end else begin
							n_depth = (depth_q == D_MAX) ? depth_q : depth_q + D_ONE;
							nev[0] = mk_ev(EV_OPEN, ERR_NONE, n_depth, mark_q[K_OPEN], off, Z, Z);
							n_mvalid[K_OPEN] = 1'b0;
						end
					end
				end
				default: begin
					if (mode_q == M_APRE && is_name(job.c)) begin
						n_mode = M_ANAME;
						n_mark[K_ANS] = off;
						n_mvalid[K_ANS] = 1'b1;
					end
				end
			endcase
		end
		for (int i = 0; i < 3; i++) begin
			if ((2'(i) == ncnt - 2'd1 && job.step_last) || nev[i].kind == EV_ERR)
				nev[i].last = 2'(i) < ncnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_TEXT;
			skip_q   <= 4'd0;
			depth_q  <= '0;
			mvalid_q <= '0;
		end else if (pop) begin
			mode_q   <= n_mode;
			skip_q   <= n_skip;
			depth_q  <= n_depth;
			mvalid_q <= n_mvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_cnt_q <= 2'd0;
			ev_ptr_q <= 2'd0;
		end else if (pop) begin
			ev_cnt_q <= ncnt;
			ev_ptr_q <= 2'd0;
		end else if (drain_last) begin
			ev_cnt_q <= 2'd0;
			ev_ptr_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			ev_ptr_q <= ev_ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q   <= nev;
			mark_q <= n_mark;
		end
	end

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ev_ptr_q < ev_cnt_q)
		else $error("event pointer beyond buffered events");

	a_fin_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && job.fin) |=> (mode_q == M_TEXT && depth_q == '0 && mvalid_q == '0))
		else $error("state not cleared after end of document");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid)
		else $error("job taken from empty queue");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && mode_q == M_HALT) |=> ev_cnt_q == 2'd0)
		else $error("event produced while halted");
endmodule
`default_nettype wire

/* src/xml_tokenizer_events_top.sv */
// Top level of the streaming XML tokenizer with SAX-style events.
`timescale 1ns / 1ps
`default_nettype none
// Takes one document byte per cycle on the slave stream while the job queue is not full, and
// returns open-tag, close-tag, attribute, end-of-attributes, text, done and error events as
// byte-offset spans on the master stream. A byte is decoded once eight later bytes sit in the
// lookahead window, so events lag the input by eight bytes. The front end feeds a four-entry
// job queue; the event engine takes one job per cycle while its event buffer is empty or
// sending its last event, and sends its events one per transfer, at most three per byte. At
// the end of the document (tlast, or a zero byte) the front end flushes the window as n+1
// jobs, n being the bytes still buffered (at most nine), and takes no byte while flushing.
module xml_tokenizer_events_top import xte_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int DEPTH_BITS  = DEPTH_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // doc_byte
	input  wire logic         s_tlast,   // end_of_doc
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [151:0]      m_tdata,   // error_code, nest_depth, name_start, name_end,
	                                     // value_start, value_end, zero pad
	output logic [2:0]        m_tuser,   // event_kind
	output logic              m_tlast    // last_result
);
	localparam int JW = $bits(job_t) + OFFSET_BITS;

	logic                   push, full, pop, jvalid;
	job_t                   fjob, bjob;
	logic [OFFSET_BITS-1:0] foff, boff;
	logic [JW-1:0]          rdata;
	event_t                 ev;

	xte_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tlast(s_tlast), .full(full), .push(push),
		.job(fjob), .job_off(foff)
	);

	xte_job_fifo #(.WIDTH(JW), .DEPTH(JOB_FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata({fjob, foff}), .full(full),
		.pop(pop), .rdata(rdata), .valid(jvalid)
	);

	assign bjob = rdata[JW-1:OFFSET_BITS];
	assign boff = rdata[OFFSET_BITS-1:0];

	xte_back #(.OFFSET_BITS(OFFSET_BITS), .DEPTH_BITS(DEPTH_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(jvalid), .job(bjob), .job_off(boff),
		.pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .ev(ev)
	);

	assign m_tdata = {5'b00000, ev.ve, ev.vs, ev.ne, ev.ns, ev.depth, ev.code};
	assign m_tuser = ev.kind;
	assign m_tlast = ev.last;
endmodule
`default_nettype wire
